### src/quadratic_root_solver_defines.svh
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

`ifndef SYNTH
// implication checked in the same cycle
`define QRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked in the next cycle
`define QRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define QRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### src/qrs_pkg.sv
// shared constants and types of the quadratic root solver
`timescale 1ns / 1ps
package qrs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int TOL_BITS      = 16;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd7;

    // kind of solution reported with each result
    typedef enum logic [2:0] {
        KIND_ONE  = 3'd0,
        KIND_TWO  = 3'd1,
        KIND_CPLX = 3'd2,
        KIND_NONE = 3'd3,
        KIND_INF  = 3'd4
    } t_root_kind;

endpackage

### src/qrs_channels.sv
// request channels of the quadratic root solver: coefficients in, roots out
`timescale 1ns / 1ps
interface qrs_coef_if #(
    parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] coef_a;
    logic signed [WORD_BITS-1:0] coef_b;
    logic signed [WORD_BITS-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_root_if #(
    parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    qrs_pkg::t_root_kind         root_kind;
    logic signed [WORD_BITS-1:0] root_one;
    logic signed [WORD_BITS-1:0] root_two;
    logic                        saturated;

    modport source (output valid, output root_kind, output root_one, output root_two,
                    output saturated, input ready);
    modport sink (input valid, input root_kind, input root_one, input root_two,
                  input saturated, output ready);
endinterface

### src/quadratic_root_solver.sv
// pipelined fixed-point quadratic root solver
//
//   channel   dir  handshake      payload
//   i_coef    in   valid/ready    coef_a, coef_b, coef_c
//   o_root    out  valid/ready    root_kind, root_one, root_two, saturated
//   i_cfg     in   write enable   zero_tolerance
//
// one request enters per cycle while o_root is not stalled; the default format is Q16.16
// depth is set by the bit-per-stage square root (WORD_BITS+1 stages) and the
// bit-per-stage dividers (WORD_BITS+2+FRAC_BITS stages)
// a stall on o_root freezes the whole pipeline; i_coef.ready follows it
// reset is synchronous and clears valid bits and the tolerance (7)
`timescale 1ns / 1ps
`include "quadratic_root_solver_defines.svh"
module quadratic_root_solver #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [qrs_pkg::TOL_BITS-1:0]  i_cfg_wdata,
    qrs_coef_if.sink                      i_coef,
    qrs_root_if.source                    o_root
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int TB  = qrs_pkg::TOL_BITS;
    localparam int DW  = 2 * W + 2;
    localparam int RW  = W + 3;
    localparam int SQ  = W + 1;
    localparam int NSW = W + 3;
    localparam int NMW = W + 2;
    localparam int DMW = W + 1;
    localparam int NB  = NMW + F;
    localparam int CW  = (DW > TB + F) ? DW : TB + F;

    typedef struct packed {
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        logic signed [W-1:0] c;
        logic                lin;
        qrs_pkg::t_root_kind kind;
    } t_meta;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [SQ-1:0] root;
        logic [DW-1:0] x;
    } t_sq;

    typedef struct packed {
        logic           neg;
        logic           nz;
        logic           use_q;
        logic [DMW-1:0] den;
        logic [DMW-1:0] rem;
        logic [NB-1:0]  quo;
        logic [NB-1:0]  num;
    } t_div;

    // magnitude of a signed word
    function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // one root bit of the square root
    function automatic t_sq f_sq(input t_sq s);
        logic [RW+1:0] sh;
        logic [RW+1:0] tr;
        t_sq           r;
        sh = {s.rem, s.x[DW-1:DW-2]};
        tr = (RW + 2)'({s.root, 2'b01});
        if (sh >= tr) begin
            r.rem  = RW'(sh - tr);
            r.root = {s.root[SQ-2:0], 1'b1};
        end else begin
            r.rem  = RW'(sh);
            r.root = {s.root[SQ-2:0], 1'b0};
        end
        r.x = {s.x[DW-3:0], 2'b00};
        return r;
    endfunction

    // one quotient bit of the restoring divider
    function automatic t_div f_dv(input t_div d);
        logic [DMW:0] sh;
        t_div         r;
        r  = d;
        sh = {d.rem, d.num[NB-1]};
        if (sh >= {1'b0, d.den}) begin
            r.rem = DMW'(sh - {1'b0, d.den});
            r.quo = {d.quo[NB-2:0], 1'b1};
        end else begin
            r.rem = DMW'(sh);
            r.quo = {d.quo[NB-2:0], 1'b0};
        end
        r.num = {d.num[NB-2:0], 1'b0};
        return r;
    endfunction

    // divider setup from signed numerator and denominator
    function automatic t_div f_dv_init(input logic [NSW-1:0] n, input logic [W+1:0] d,
                                       input logic sgn, input logic use_q);
        logic [NSW-1:0] nm;
        logic [W+1:0]   dm;
        t_div           r;
        nm      = n[NSW-1] ? (~n + 1'b1) : n;
        dm      = d[W+1] ? (~d + 1'b1) : d;
        r.neg   = sgn;
        r.nz    = (nm != '0);
        r.use_q = use_q;
        r.den   = dm[DMW-1:0];
        r.rem   = '0;
        r.quo   = '0;
        r.num   = {nm[NMW-1:0], {F{1'b0}}};
        return r;
    endfunction

    // saturate and sign a finished quotient, {saturated, value}
    function automatic logic [W:0] f_fin(input t_div d);
        logic [NB-1:0] lim;
        logic [W-1:0]  v;
        logic          sat;
        lim = NB'(1) << (W - 1);
        if (!d.neg) begin
            lim = lim - 1'b1;
        end
        sat = 1'b0;
        if (!d.use_q || !d.nz) begin
            v = '0;
        end else if (d.quo > lim) begin
            v   = lim[W-1:0];
            sat = 1'b1;
        end else begin
            v = d.quo[W-1:0];
        end
        if (d.neg) begin
            v = ~v + 1'b1;
        end
        return {sat, v};
    endfunction

    logic [TB-1:0] r_tol;
    logic          w_adv;

    logic                r_s1_v;
    logic signed [W-1:0] r_s1_a, r_s1_b, r_s1_c;
    logic [W-1:0]        r_s1_ma, r_s1_mb, r_s1_mc;

    logic                r_s2_v;
    logic signed [W-1:0] r_s2_a, r_s2_b, r_s2_c;
    logic [2*W-1:0]      r_s2_b2, r_s2_ac;
    logic                r_s2_asm, r_s2_bsm, r_s2_csm, r_s2_pneg;
    logic [2*W-1:0]      n_b2, n_ac;

    logic                r_s3_v;
    logic signed [W-1:0] r_s3_a, r_s3_b, r_s3_c;
    logic [DW-1:0]       r_s3_dm;
    logic                r_s3_dneg, r_s3_asm, r_s3_bsm, r_s3_csm;
    logic [DW-1:0]       n_dm;
    logic                n_dneg;

    logic [SQ-1:0] r_sq_v;
    t_sq           r_sq [SQ];
    t_meta         r_sq_meta [SQ];
    t_meta         n_meta;
    t_sq           n_sq0;

    logic  r_nm_v;
    t_meta r_nm_meta;
    t_div  r_nm_d1, r_nm_d2;
    t_div  n_d1, n_d2;

    logic [NB-1:0] r_dv_v;
    t_div          r_dv1 [NB];
    t_div          r_dv2 [NB];
    t_meta         r_dv_meta [NB];

    logic                r_out_valid;
    qrs_pkg::t_root_kind r_out_kind;
    logic signed [W-1:0] r_out_one, r_out_two;
    logic                r_out_sat;
    logic [W:0]          n_fin1, n_fin2;

    // pipeline moves whenever the output register is free or being taken
    assign w_adv        = !r_out_valid || o_root.ready;
    assign i_coef.ready = w_adv;

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= qrs_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_sq_v      <= '0;
            r_nm_v      <= 1'b0;
            r_dv_v      <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_v      <= i_coef.valid;
            r_s2_v      <= r_s1_v;
            r_s3_v      <= r_s2_v;
            r_sq_v      <= {r_sq_v[SQ-2:0], r_s3_v};
            r_nm_v      <= r_sq_v[SQ-1];
            r_dv_v      <= {r_dv_v[NB-2:0], r_nm_v};
            r_out_valid <= r_dv_v[NB-1];
        end
    end

    // products for the discriminant
    assign n_b2 = {{W{1'b0}}, r_s1_mb} * {{W{1'b0}}, r_s1_mb};
    assign n_ac = {{W{1'b0}}, r_s1_ma} * {{W{1'b0}}, r_s1_mc};

    // discriminant magnitude and sign
    always_comb begin
        n_dneg = 1'b0;
        if (r_s2_pneg) begin
            n_dm = {2'b00, r_s2_b2} + {r_s2_ac, 2'b00};
        end else if ({2'b00, r_s2_b2} >= {r_s2_ac, 2'b00}) begin
            n_dm = {2'b00, r_s2_b2} - {r_s2_ac, 2'b00};
        end else begin
            n_dm   = {r_s2_ac, 2'b00} - {2'b00, r_s2_b2};
            n_dneg = 1'b1;
        end
    end

    // classify the equation
    always_comb begin
        n_meta.a   = r_s3_a;
        n_meta.b   = r_s3_b;
        n_meta.c   = r_s3_c;
        n_meta.lin = r_s3_asm;
        priority if (r_s3_asm && !r_s3_bsm) begin
            n_meta.kind = qrs_pkg::KIND_ONE;
        end else if (r_s3_asm && !r_s3_csm) begin
            n_meta.kind = qrs_pkg::KIND_NONE;
        end else if (r_s3_asm) begin
            n_meta.kind = qrs_pkg::KIND_INF;
        end else if (CW'(r_s3_dm) < (CW'(r_tol) << F)) begin
            n_meta.kind = qrs_pkg::KIND_ONE;
        end else if (!r_s3_dneg) begin
            n_meta.kind = qrs_pkg::KIND_TWO;
        end else begin
            n_meta.kind = qrs_pkg::KIND_CPLX;
        end
        n_sq0.rem  = '0;
        n_sq0.root = '0;
        n_sq0.x    = r_s3_dm;
    end

    // numerators and denominators for both dividers
    always_comb begin
        logic signed [NSW-1:0] nb, ns, nc, n1, n2;
        logic signed [W+1:0]   a2, d1;
        t_meta                 m;
        logic                  two, use1, use2;
        m    = r_sq_meta[SQ-1];
        two  = (m.kind == qrs_pkg::KIND_TWO);
        use1 = (m.kind == qrs_pkg::KIND_ONE) || two || (m.kind == qrs_pkg::KIND_CPLX);
        use2 = two || (m.kind == qrs_pkg::KIND_CPLX);
        nb   = -NSW'($signed(m.b));
        nc   = -NSW'($signed(m.c));
        ns   = $signed(NSW'(r_sq[SQ-1].root));
        a2   = $signed({m.a[W-1], m.a, 1'b0});
        d1   = m.lin ? $signed({{2{m.b[W-1]}}, m.b}) : a2;
        n1   = m.lin ? nc : (two ? nb + ns : nb);
        n2   = two ? nb - ns : ns;
        n_d1 = f_dv_init(n1, d1, n1[NSW-1] ^ d1[W+1], use1);
        n_d2 = f_dv_init(n2, a2, two & (n2[NSW-1] ^ a2[W+1]), use2);
    end

    assign n_fin1 = f_fin(r_dv1[NB-1]);
    assign n_fin2 = f_fin(r_dv2[NB-1]);

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_a  <= i_coef.coef_a;
            r_s1_b  <= i_coef.coef_b;
            r_s1_c  <= i_coef.coef_c;
            r_s1_ma <= f_mag(i_coef.coef_a);
            r_s1_mb <= f_mag(i_coef.coef_b);
            r_s1_mc <= f_mag(i_coef.coef_c);

            r_s2_a    <= r_s1_a;
            r_s2_b    <= r_s1_b;
            r_s2_c    <= r_s1_c;
            r_s2_b2   <= n_b2;
            r_s2_ac   <= n_ac;
            r_s2_asm  <= r_s1_ma < W'(r_tol);
            r_s2_bsm  <= r_s1_mb < W'(r_tol);
            r_s2_csm  <= r_s1_mc < W'(r_tol);
            r_s2_pneg <= r_s1_a[W-1] ^ r_s1_c[W-1];

            r_s3_a    <= r_s2_a;
            r_s3_b    <= r_s2_b;
            r_s3_c    <= r_s2_c;
            r_s3_dm   <= n_dm;
            r_s3_dneg <= n_dneg;
            r_s3_asm  <= r_s2_asm;
            r_s3_bsm  <= r_s2_bsm;
            r_s3_csm  <= r_s2_csm;

            r_sq[0]      <= f_sq(n_sq0);
            r_sq_meta[0] <= n_meta;
            for (int k = 1; k < SQ; k++) begin
                r_sq[k]      <= f_sq(r_sq[k-1]);
                r_sq_meta[k] <= r_sq_meta[k-1];
            end

            r_nm_meta <= r_sq_meta[SQ-1];
            r_nm_d1   <= n_d1;
            r_nm_d2   <= n_d2;

            r_dv1[0]     <= f_dv(r_nm_d1);
            r_dv2[0]     <= f_dv(r_nm_d2);
            r_dv_meta[0] <= r_nm_meta;
            for (int k = 1; k < NB; k++) begin
                r_dv1[k]     <= f_dv(r_dv1[k-1]);
                r_dv2[k]     <= f_dv(r_dv2[k-1]);
                r_dv_meta[k] <= r_dv_meta[k-1];
            end

            r_out_kind <= r_dv_meta[NB-1].kind;
            r_out_one  <= n_fin1[W-1:0];
            r_out_two  <= n_fin2[W-1:0];
            r_out_sat  <= n_fin1[W] | n_fin2[W];
        end
    end

    // result port
    assign o_root.valid     = r_out_valid;
    assign o_root.root_kind = r_out_kind;
    assign o_root.root_one  = r_out_one;
    assign o_root.root_two  = r_out_two;
    assign o_root.saturated = r_out_sat;

    // checks
    `QRS_ASSERT_IMP(a_noroot_zero, i_clk, i_rst_n, r_out_valid && (r_out_kind == qrs_pkg::KIND_NONE || r_out_kind == qrs_pkg::KIND_INF), r_out_one == '0 && r_out_two == '0 && !r_out_sat, "no-root result carries values")
    `QRS_ASSERT_IMP(a_one_second_zero, i_clk, i_rst_n, r_out_valid && r_out_kind == qrs_pkg::KIND_ONE, r_out_two == '0, "single root result has second value")
    `QRS_ASSERT_IMP(a_cplx_imag_pos, i_clk, i_rst_n, r_out_valid && r_out_kind == qrs_pkg::KIND_CPLX, !r_out_two[W-1], "imaginary part is negative")
    `QRS_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_coef.valid && w_adv, r_s1_v, "accepted request missing in first stage")
    `QRS_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, !w_adv, $stable(r_dv_v) && $stable(r_sq_v), "pipeline moved during stall")

endmodule

### sim/quadratic_root_solver_test.sv
// self-checking testbench for the quadratic root solver: directed and random equations
`timescale 1ns / 1ps
module quadratic_root_solver_test;

    localparam int FRAC      = qrs_pkg::FRAC_BITS_DEF;
    localparam int WORD      = qrs_pkg::WORD_BITS_DEF;
    localparam int LATENCY   = 2 * WORD + FRAC + 8;
    localparam int IDLE_MAX  = 5000;
    localparam int RAND_ITEMS = 104;

    typedef logic signed [WORD-1:0] t_word;

    typedef struct {
        qrs_pkg::t_root_kind kind;
        t_word               root_one;
        t_word               root_two;
        logic                saturated;
    } t_roots;

    // predicts the roots of each request and checks results in order
    class root_scoreboard;
        t_roots expected_roots[$];
        int     errors;
        bit     clip;

        function automatic logic [63:0] magnitude(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        function automatic logic [63:0] wide_sqrt(logic [127:0] v);
            logic [63:0] r;
            logic [63:0] t;
            r = '0;
            for (int i = 63; i >= 0; i--) begin
                t = r | (64'd1 << i);
                if ({64'd0, t} * {64'd0, t} <= v) r = t;
            end
            return r;
        endfunction

        // (num << FRAC) / den, truncated toward zero, then clipped
        function automatic t_word fixed_div(longint num, longint den);
            bit           neg;
            logic [63:0]  nm;
            logic [63:0]  dm;
            logic [63:0]  limit;
            logic [127:0] q;
            neg = (num < 0) != (den < 0);
            nm = magnitude(num);
            dm = magnitude(den);
            limit = (64'd1 << (WORD - 1)) - (neg ? 64'd0 : 64'd1);
            if (nm == 0) return '0;
            if (dm == 0) begin
                clip = 1;
                return neg ? t_word'(-limit) : t_word'(limit);
            end
            q = ({64'd0, nm} << FRAC) / {64'd0, dm};
            if (q > {64'd0, limit}) begin
                clip = 1;
                q = {64'd0, limit};
            end
            return neg ? t_word'(-q[63:0]) : t_word'(q[63:0]);
        endfunction

        function automatic void note_request(t_word ca, t_word cb, t_word cc,
                                             logic [qrs_pkg::TOL_BITS-1:0] tol);
            longint       a;
            longint       b;
            longint       c;
            longint       a2;
            longint       s;
            logic [127:0] b_sq;
            logic [127:0] ac4;
            logic [127:0] disc;
            bit           disc_neg;
            t_roots       r;
            a = ca; b = cb; c = cc;
            a2 = 2 * a;
            clip = 0;
            r.root_one = '0;
            r.root_two = '0;
            disc_neg = 0;
            if (magnitude(a) < tol) begin
                // degenerate: linear, none or infinite
                if (magnitude(b) >= tol) begin
                    r.root_one = fixed_div(-c, b);
                    r.kind = qrs_pkg::KIND_ONE;
                end else if (magnitude(c) >= tol) begin
                    r.kind = qrs_pkg::KIND_NONE;
                end else begin
                    r.kind = qrs_pkg::KIND_INF;
                end
            end else begin
                b_sq = {64'd0, magnitude(b)} * {64'd0, magnitude(b)};
                ac4 = ({64'd0, magnitude(a)} * {64'd0, magnitude(c)}) << 2;
                if ((a < 0) != (c < 0)) disc = b_sq + ac4;
                else if (b_sq >= ac4) disc = b_sq - ac4;
                else begin
                    disc = ac4 - b_sq;
                    disc_neg = 1;
                end
                if (disc < ({112'd0, tol} << FRAC)) begin
                    r.root_one = fixed_div(-b, a2);
                    r.kind = qrs_pkg::KIND_ONE;
                end else if (!disc_neg) begin
                    s = longint'(wide_sqrt(disc));
                    r.root_one = fixed_div(-b + s, a2);
                    r.root_two = fixed_div(-b - s, a2);
                    r.kind = qrs_pkg::KIND_TWO;
                end else begin
                    s = longint'(wide_sqrt(disc));
                    r.root_one = fixed_div(-b, a2);
                    r.root_two = fixed_div(s, longint'(magnitude(a2)));
                    r.kind = qrs_pkg::KIND_CPLX;
                end
            end
            r.saturated = clip;
            expected_roots.push_back(r);
        endfunction

        task automatic report(string what);
            $display("[%0t] roots mismatch: %s", $realtime, what);
            errors++;
        endtask

        task automatic check_roots(t_roots got);
            t_roots e;
            if (expected_roots.size() == 0) begin
                report("result with no request outstanding");
                return;
            end
            e = expected_roots.pop_front();
            if (got.kind != e.kind)
                report($sformatf("kind %0d, want %0d", got.kind, e.kind));
            if (got.root_one !== e.root_one)
                report($sformatf("root_one %h, want %h", got.root_one, e.root_one));
            if (got.root_two !== e.root_two)
                report($sformatf("root_two %h, want %h", got.root_two, e.root_two));
            if (got.saturated !== e.saturated)
                report($sformatf("saturated %b, want %b", got.saturated, e.saturated));
        endtask
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [qrs_pkg::TOL_BITS-1:0] i_cfg_wdata;
    logic [qrs_pkg::TOL_BITS-1:0] tolerance;
    int                           idle_cycles = 0;
    bit                           calm = 1'b0;

    qrs_coef_if coef_ch ();
    qrs_root_if root_ch ();

    root_scoreboard roots_sb = new();

    quadratic_root_solver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_coef      (coef_ch),
        .o_root      (root_ch)
    );

    // clock
    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // gap length: mostly short, a few long, none while calm
    function automatic int pick_gap();
        if (calm) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // calm stretches with no idling on either side
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) calm <= ~calm;
    end

    // result side stalls
    initial begin
        int stall;
        root_ch.ready = 0;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                root_ch.ready <= 0;
                stall--;
            end else begin
                root_ch.ready <= 1;
                stall = pick_gap();
            end
        end
    end

    // check results
    always @(posedge i_clk) begin
        t_roots got;
        if (i_rst_n) begin
            if (root_ch.valid && root_ch.ready) begin
                got.kind = root_ch.root_kind;
                got.root_one = root_ch.root_one;
                got.root_two = root_ch.root_two;
                got.saturated = root_ch.saturated;
                roots_sb.check_roots(got);
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((coef_ch.valid && coef_ch.ready) || (root_ch.valid && root_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_tolerance(logic [qrs_pkg::TOL_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= value;
        tolerance = value;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    // one request, held until accepted
    task automatic send_request(t_word ca, t_word cb, t_word cc);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            coef_ch.valid <= 0;
        end
        @(negedge i_clk);
        coef_ch.valid <= 1;
        coef_ch.coef_a <= ca;
        coef_ch.coef_b <= cb;
        coef_ch.coef_c <= cc;
        do @(posedge i_clk); while (!coef_ch.ready);
        roots_sb.note_request(ca, cb, cc, tolerance);
    endtask

    task automatic drain();
        @(negedge i_clk);
        coef_ch.valid <= 0;
        while (roots_sb.expected_roots.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 12) @(posedge i_clk);
    endtask

    // random value scaled into a Q16.16 range
    function automatic t_word rand_coef(int kind);
        t_word v;
        case (kind)
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 40)) - 20;
            2: v = ($signed($urandom_range(0, 16)) - 8) <<< FRAC;
            default: v = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        endcase
        return v;
    endfunction

    task automatic directed_requests();
        const t_word one = 1 << FRAC;
        send_request(0, 0, 0);
        send_request(0, 0, one);
        send_request(0, 0, 5);
        send_request(0, 2 * one, -4 * one);
        send_request(3, 5, -6);
        send_request(1, 32'sh7fffffff, 0);
        send_request(0, 1, 32'sh7fffffff);
        send_request(one, -2 * one, one);
        send_request(one, -3 * one, 2 * one);
        send_request(one, 0, one);
        send_request(-one, 0, 4 * one);
        send_request(32'sh7fffffff, 32'sh80000000, 32'sh80000000);
        send_request(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        send_request(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_request(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_request(7, 32'sh7fffffff, 32'sh80000000);
        send_request(8, 32'sh80000000, 32'sh7fffffff);
        send_request(-8, 0, 32'sh7fffffff);
        send_request(1, 0, 0);
        send_request(32'shffffffff, 32'sh00000001, 32'shffffffff);
        send_request(one, 0, 0);
    endtask

    task automatic random_requests(int count);
        int ka;
        for (int n = 0; n < count; n++) begin
            ka = $urandom_range(0, 4);
            send_request(ka == 4 ? rand_coef(1) : rand_coef(ka),
                         rand_coef($urandom_range(0, 3)),
                         rand_coef($urandom_range(0, 3)));
        end
    endtask

    // stimulus over several tolerance settings
    initial begin
        logic [qrs_pkg::TOL_BITS-1:0] settings[5];
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_wdata = '0;
        coef_ch.valid = 0;
        coef_ch.coef_a = '0;
        coef_ch.coef_b = '0;
        coef_ch.coef_c = '0;
        tolerance = qrs_pkg::TOL_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        settings[0] = qrs_pkg::TOL_RESET;
        settings[1] = 16'd0;
        settings[2] = 16'hffff;
        settings[3] = 16'd1;
        settings[4] = $urandom_range(2, 65534);
        directed_requests();
        random_requests(RAND_ITEMS);
        drain();
        foreach (settings[p]) begin
            write_tolerance(settings[p]);
            directed_requests();
            random_requests(RAND_ITEMS);
            drain();
        end
        if (roots_sb.errors == 0 && roots_sb.expected_roots.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
